FILE: rtl/core/albd_pkg.sv
// shared constants and types for the ambient light backlight duty core
package albd_pkg;

  // sample window
  localparam int unsigned WINDOW      = 100;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned FILL_BITS   = $clog2(WINDOW + 1);
  localparam int unsigned SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW);

  // duty in tens of percent, 1..10, zero when no update
  localparam int unsigned TENS_BITS   = 4;
  localparam int unsigned PCT_BITS    = 7;
  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned PROD_BITS   = TENS_BITS + PERIOD_BITS;

  localparam logic [TENS_BITS-1:0] TENS_MIN = TENS_BITS'(1);
  localparam logic [TENS_BITS-1:0] TENS_MAX = TENS_BITS'(10);

  // divide by ten as (x >> 1) / 5, with x/5 = (x * RECIP5) >> RECIP_SHIFT
  localparam int unsigned RECIP_BITS  = 19;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam logic [RECIP_BITS-1:0] RECIP5 = RECIP_BITS'(419431);
  localparam int unsigned QPROD_BITS  = (PROD_BITS - 1) + RECIP_BITS;

  // register reset values
  localparam logic [11:0] DARK_RESET   = 12'd62;
  localparam logic [15:0] PERIOD_RESET = 16'd3125;
  localparam logic [3:0]  LEVEL_RESET  = 4'd10;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE = 3'd0,
    REG_AUTO   = 3'd1,
    REG_LEVEL  = 3'd2,
    REG_DARK   = 3'd3,
    REG_PERIOD = 3'd4
  } cfg_reg_e;

  // what the first stage decided for a request
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_AUTO  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [TENS_BITS-1:0] tens;
  } stage_a_t;

  typedef struct packed {
    logic [TENS_BITS-1:0] tens;
    logic                 err;
  } stage_b_t;

  typedef struct packed {
    logic                 upd;
    logic [PCT_BITS-1:0]  pct;
    logic [PROD_BITS-1:0] prod;
    logic                 err;
  } stage_c_t;

endpackage

FILE: rtl/core/albd_cell.sv
// one window cell: holds a sample, passes it on when the window shifts
module albd_cell import albd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] sample_o
);

  logic [SAMPLE_BITS-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

FILE: rtl/core/albd_window.sv
// sample window as a chain of cells, oldest sample at the tail
module albd_window import albd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SAMPLE_BITS-1:0] tail_o
);

  logic [SAMPLE_BITS-1:0] link [WINDOW+1];

  assign link[0] = sample_i;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    albd_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift_i),
      .sample_i (link[g]),
      .sample_o (link[g+1])
    );
  end

  assign tail_o = link[WINDOW];

endmodule

FILE: rtl/core/ambient_light_backlight_duty_core.sv
// top level of the ambient light backlight duty core
//
// usage
// - input channel (in_valid_i / in_ready_o): one request per tick with
//   settings_ready_i, alarm_active_i and light_sample_i
// - output channel (out_valid_o / out_ready_i): exactly one result per
//   request, in order: duty_update_o, duty_percent_o, compare_count_o and
//   the sticky sensor_failed_o flag
// - config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (0 enable, 1 auto mode, 2 level, 3 dark threshold, 4 pwm period);
//   other indexes are ignored; write only while no request is in flight
// - pipeline: the decision is registered at accept, then duty select, period
//   multiply, divide by ten into the output register
// - throughput: one request per cycle when not stalled; the window is a chain of
//   cells that shifts once per auto request and a running sum replaces any scan
// - reset: registers take their reset values, fill count, running sum and
//   sticky flag clear (the window holds no reset, the fill count masks stale cells)
// - stall: when out_ready_i is low the pipeline fills up, holding its
//   contents; in_ready_o drops only once all four stages are occupied
module ambient_light_backlight_duty_core import albd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [PERIOD_BITS-1:0]  cfg_wdata_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    settings_ready_i,
  input  logic                    alarm_active_i,
  input  logic [11:0]             light_sample_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    duty_update_o,
  output logic [PCT_BITS-1:0]     duty_percent_o,
  output logic [PERIOD_BITS-1:0]  compare_count_o,
  output logic                    sensor_failed_o
);

  // ---------------------------------------------------------------------
  // config registers; dark threshold kept pre-scaled by the window size
  // ---------------------------------------------------------------------
  logic                   enable_q;
  logic                   auto_q;
  logic [3:0]             level_q;
  logic [SUM_BITS-1:0]    thr_sum_q;
  logic [PERIOD_BITS-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      auto_q    <= 1'b1;
      level_q   <= LEVEL_RESET;
      thr_sum_q <= SUM_BITS'(DARK_RESET) * SUM_BITS'(WINDOW);
      period_q  <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENABLE: enable_q  <= cfg_wdata_i[0];
        REG_AUTO:   auto_q    <= cfg_wdata_i[0];
        REG_LEVEL:  level_q   <= cfg_wdata_i[3:0];
        REG_DARK:   thr_sum_q <= SUM_BITS'(cfg_wdata_i[11:0]) * SUM_BITS'(WINDOW);
        REG_PERIOD: period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // pipeline handshake: each stage moves when the next one has room
  // ---------------------------------------------------------------------
  logic a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  logic a_ready, b_ready, c_ready, o_ready;

  assign o_ready = !o_valid_q || out_ready_i;
  assign c_ready = !c_valid_q || o_ready;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;

  assign in_ready_o = a_ready;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // accept: classify the request, shift the window, keep the running sum
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] tail;
  logic [SAMPLE_BITS-1:0] leaving;
  logic [FILL_BITS-1:0]   fill_q, fill_d;
  logic [SUM_BITS-1:0]    sum_q, sum_d;
  logic                   win_full;
  logic                   shift;
  stage_a_t               a_d, a_q;

  assign sample   = light_sample_i[SAMPLE_BITS-1:0];
  assign win_full = (fill_q == FILL_BITS'(WINDOW));
  // until the window is full the tail cell was never written
  assign leaving  = win_full ? tail : '0;

  always_comb begin
    a_d.kind = KIND_NONE;
    a_d.tens = '0;
    shift    = 1'b0;
    fill_d   = fill_q;
    sum_d    = sum_q;
    if (settings_ready_i && enable_q) begin
      if (alarm_active_i) begin
        a_d.kind = KIND_FIXED;
        a_d.tens = TENS_MAX;
      end else if (auto_q) begin
        shift = in_fire;
        sum_d = sum_q - SUM_BITS'(leaving) + SUM_BITS'(sample);
        if (win_full) begin
          a_d.kind = KIND_AUTO;
        end else begin
          fill_d = fill_q + FILL_BITS'(1);
        end
      end else begin
        // manual level, clamped to 10..100 percent
        a_d.kind = KIND_FIXED;
        if (level_q == '0) begin
          a_d.tens = TENS_MIN;
        end else if (level_q > TENS_MAX) begin
          a_d.tens = TENS_MAX;
        end else begin
          a_d.tens = level_q;
        end
      end
    end
  end

  albd_window u_window (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .sample_i (sample),
    .tail_o   (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (shift) begin
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q <= a_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage b: threshold compare on the sum that includes this sample,
  // sticky sensor fail on an all-zero window
  // ---------------------------------------------------------------------
  logic     a_move;
  logic     zero_hit;
  logic     err_q;
  stage_b_t b_d, b_q;

  assign a_move   = a_valid_q && b_ready;
  assign zero_hit = (a_q.kind == KIND_AUTO) && (sum_q == '0);

  always_comb begin
    b_d.err = err_q || zero_hit;
    case (a_q.kind)
      KIND_AUTO:  b_d.tens = (sum_q < thr_sum_q) ? TENS_MIN : TENS_MAX;
      KIND_FIXED: b_d.tens = a_q.tens;
      default:    b_d.tens = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else if (a_move && zero_hit) begin
      err_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_q <= b_d;
    end
  end

  // ---------------------------------------------------------------------
  // stage c: tens times period, percent; zero tens means no update
  // ---------------------------------------------------------------------
  stage_c_t c_d, c_q;

  always_comb begin
    c_d.upd  = (b_q.tens != '0);
    c_d.pct  = PCT_BITS'(b_q.tens) * PCT_BITS'(10);
    c_d.prod = PROD_BITS'(b_q.tens) * PROD_BITS'(period_q);
    c_d.err  = b_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_ready) begin
      c_q <= c_d;
    end
  end

  // ---------------------------------------------------------------------
  // output stage: divide by ten as a reciprocal multiply, exact here
  // ---------------------------------------------------------------------
  logic [QPROD_BITS-1:0]  qprod;
  logic                   upd_q;
  logic [PCT_BITS-1:0]    pct_q;
  logic [PERIOD_BITS-1:0] count_q;
  logic                   fail_q;

  assign qprod = QPROD_BITS'(c_q.prod[PROD_BITS-1:1]) * QPROD_BITS'(RECIP5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_q && o_ready) begin
      upd_q   <= c_q.upd;
      pct_q   <= c_q.pct;
      count_q <= qprod[RECIP_SHIFT +: PERIOD_BITS];
      fail_q  <= c_q.err;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign duty_update_o   = upd_q;
  assign duty_percent_o  = pct_q;
  assign compare_count_o = count_q;
  assign sensor_failed_o = fail_q;

`ifndef SYNTHESIS
  // fill count saturates at the window size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_BITS'(WINDOW))
    else $error("fill count beyond window size");

  // sensor fail flag never clears once set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("sticky sensor fail flag cleared");

  // a result without update carries zero duty and count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !duty_update_o) |-> (duty_percent_o == '0 && compare_count_o == '0))
    else $error("non-update result with nonzero duty");

  // an updating result stays within 10..100 percent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && duty_update_o) |->
      (duty_percent_o >= PCT_BITS'(10) && duty_percent_o <= PCT_BITS'(100)))
    else $error("duty percent outside clamp range");

  // the window only moves when a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> in_fire)
    else $error("window shifted without accepted request");
`endif

endmodule

FILE: test/backlight_duty_checker.sv
// request/result monitor with its own duty prediction for the backlight duty core
module backlight_duty_checker import albd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [PERIOD_BITS-1:0]  cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    settings_ready_i,
  input  logic                    alarm_active_i,
  input  logic [11:0]             light_sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic                    duty_update_i,
  input  logic [PCT_BITS-1:0]     duty_percent_i,
  input  logic [PERIOD_BITS-1:0]  compare_count_i,
  input  logic                    sensor_failed_i,
  output int unsigned             results_owed_o,
  output int unsigned             mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_DEPTH   = 100;
  localparam int unsigned DUTY_FLOOR   = 10;
  localparam int unsigned DUTY_CEIL    = 100;
  localparam int unsigned REPORT_LINES = 40;

  typedef struct packed {
    logic                   update;
    logic [PCT_BITS-1:0]    percent;
    logic [PERIOD_BITS-1:0] count;
    logic                   failed;
  } duty_result_t;

  // settings copy
  logic                   backlight_on;
  logic                   auto_on;
  logic [3:0]             level_q;
  logic [11:0]            dark_code;
  logic [PERIOD_BITS-1:0] period_q;

  // ambient window copy
  logic [11:0]  ring [RING_DEPTH];
  int unsigned  ring_sum;
  int unsigned  ring_pos;
  int unsigned  ring_fill;
  logic         sensor_fault;

  duty_result_t expected_duty_q [$];
  int unsigned  mismatch_count;

  assign mismatch_count_o = mismatch_count;

  function automatic duty_result_t predict_duty(logic ready, logic alarm, logic [11:0] sample);
    duty_result_t res;
    int unsigned  duty;
    logic         update;
    res    = '0;
    duty   = 0;
    update = 1'b0;
    if (ready && backlight_on) begin
      if (alarm) begin
        duty   = DUTY_CEIL;
        update = 1'b1;
      end else if (auto_on) begin
        ring_sum       = ring_sum - ring[ring_pos] + sample;
        ring[ring_pos] = sample;
        ring_pos       = (ring_pos == RING_DEPTH - 1) ? 0 : ring_pos + 1;
        if (ring_fill < RING_DEPTH) begin
          ring_fill++;
        end else begin
          duty   = (ring_sum < dark_code * RING_DEPTH) ? DUTY_FLOOR : DUTY_CEIL;
          update = 1'b1;
          if (ring_sum == 0) sensor_fault = 1'b1;
        end
      end else begin
        duty   = level_q * 10;
        update = 1'b1;
      end
    end
    if (update) begin
      if (duty > DUTY_CEIL) duty = DUTY_CEIL;
      if (duty < DUTY_FLOOR) duty = DUTY_FLOOR;
      res.update  = 1'b1;
      res.percent = PCT_BITS'(duty);
      res.count   = PERIOD_BITS'((duty * period_q) / 100);
    end
    res.failed = sensor_fault;
    return res;
  endfunction

  task automatic report_duty_mismatch(string why, duty_result_t got, duty_result_t want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display({"%0t duty result %s: got upd=%0d pct=%0d cnt=%0d fail=%0d,",
                " want upd=%0d pct=%0d cnt=%0d fail=%0d"},
               $realtime, why, got.update, got.percent, got.count, got.failed,
               want.update, want.percent, want.count, want.failed);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_result_t got;
    duty_result_t want;
    if (!rst_ni) begin
      backlight_on   = 1'b0;
      auto_on        = 1'b1;
      level_q        = 4'd10;
      dark_code      = 12'd62;
      period_q       = 16'd3125;
      ring           = '{default: '0};
      ring_sum       = 0;
      ring_pos       = 0;
      ring_fill      = 0;
      sensor_fault   = 1'b0;
      mismatch_count = 0;
      expected_duty_q.delete();
      results_owed_o <= 0;
    end else begin
      // settings only change while nothing is in flight
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLE: backlight_on = cfg_wdata_i[0];
          REG_AUTO:   auto_on      = cfg_wdata_i[0];
          REG_LEVEL:  level_q      = cfg_wdata_i[3:0];
          REG_DARK:   dark_code    = cfg_wdata_i[11:0];
          REG_PERIOD: period_q     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_duty_q.push_back(predict_duty(settings_ready_i, alarm_active_i, light_sample_i));
      if (out_valid_i && out_ready_i) begin
        got = '{duty_update_i, duty_percent_i, compare_count_i, sensor_failed_i};
        if (expected_duty_q.size() == 0) begin
          report_duty_mismatch("with no request pending", got, '0);
        end else begin
          want = expected_duty_q.pop_front();
          if (got !== want) report_duty_mismatch("mismatch", got, want);
        end
      end
      results_owed_o <= expected_duty_q.size();
    end
  end

endmodule

FILE: test/ambient_light_backlight_duty_core_tb.sv
// stimulus and verdict for the ambient light backlight duty core
module ambient_light_backlight_duty_core_tb import albd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET    = 1400;
  localparam int unsigned DRAIN_CYCLES   = 8;     // idle wait after every result is back
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // far above the longest legal quiet stretch

  // indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [PERIOD_BITS-1:0]  cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    settings_ready_i;
  logic                    alarm_active_i;
  logic [11:0]             light_sample_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    duty_update_o;
  logic [PCT_BITS-1:0]     duty_percent_o;
  logic [PERIOD_BITS-1:0]  compare_count_o;
  logic                    sensor_failed_o;

  int unsigned results_owed;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned items_sent;
  bit          send_gaps_on;
  bit          stall_on;

  ambient_light_backlight_duty_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .settings_ready_i (settings_ready_i),
    .alarm_active_i   (alarm_active_i),
    .light_sample_i   (light_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .duty_update_o    (duty_update_o),
    .duty_percent_o   (duty_percent_o),
    .compare_count_o  (compare_count_o),
    .sensor_failed_o  (sensor_failed_o)
  );

  // predicts every request and compares every result
  backlight_duty_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .settings_ready_i (settings_ready_i),
    .alarm_active_i   (alarm_active_i),
    .light_sample_i   (light_sample_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .duty_update_i    (duty_update_o),
    .duty_percent_i   (duty_percent_o),
    .compare_count_i  (compare_count_o),
    .sensor_failed_i  (sensor_failed_o),
    .results_owed_o   (results_owed),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom_range(12, 40);
    if (pick < 8) return $urandom_range(1, 3);
    return 0;
  endfunction

  // result side back-pressure
  initial begin : result_backpressure
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (stall_on && $urandom_range(0, 5) == 0) hold = gap_len();
      end
    end
  end

  // hang detection: any accepted request, result or register write resets the count
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // one request; valid is raised after the gap and held until taken
  task automatic send_request(logic ready, logic alarm, logic [11:0] sample);
    int unsigned gap;
    gap = send_gaps_on ? gap_len() : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    settings_ready_i <= ready;
    alarm_active_i   <= alarm;
    light_sample_i   <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
  endtask

  // block fully drained before any register write
  task automatic quiesce();
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // writes all five registers, junk above the narrow ones' widths, optional spare indexes
  task automatic program_settings(logic en, logic au, logic [3:0] lvl, logic [11:0] thr,
                                  logic [PERIOD_BITS-1:0] per, bit spare);
    logic [CFG_IDX_BITS-1:0] idx_seq [$];
    logic [PERIOD_BITS-1:0]  val_seq [$];
    idx_seq.push_back(REG_ENABLE); val_seq.push_back({15'($urandom), en});
    idx_seq.push_back(REG_AUTO);   val_seq.push_back({15'($urandom), au});
    idx_seq.push_back(REG_LEVEL);  val_seq.push_back({12'($urandom), lvl});
    idx_seq.push_back(REG_DARK);   val_seq.push_back({4'($urandom), thr});
    idx_seq.push_back(REG_PERIOD); val_seq.push_back(per);
    if (spare) begin
      for (int s = IDX_SPARE_LO; s <= IDX_SPARE_HI; s++) begin
        idx_seq.push_back(CFG_IDX_BITS'(s));
        val_seq.push_back(16'($urandom));
      end
    end
    foreach (idx_seq[k]) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx_seq[k];
      cfg_wdata_i <= val_seq[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic                   en, au, rdy, alm;
    logic [3:0]             lvl;
    logic [11:0]            thr, smp;
    logic [PERIOD_BITS-1:0] per;
    int unsigned            style, count, idle_mode;
    int                     near;
    bit                     fault_phase_done;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= REG_ENABLE;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    settings_ready_i <= 1'b0;
    alarm_active_i   <= 1'b0;
    light_sample_i   <= '0;
    send_gaps_on     = 1'b0;
    stall_on         = 1'b0;
    items_sent       = 0;
    fault_phase_done = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: backlight off, so no request updates the duty
    send_request(1'b1, 1'b0, 12'h000);
    send_request(1'b1, 1'b1, 12'hFFF);
    send_request(1'b0, 1'b1, 12'hAAA);
    send_request(1'b1, 1'b0, 12'h555);

    // manual level zero clamps up to 10 percent, alarm forces full, not ready is ignored;
    // writes to unused indexes must not disturb anything
    quiesce();
    program_settings(1'b1, 1'b0, 4'd0, 12'hFFF, 16'hFFFF, 1'b1);
    send_request(1'b1, 1'b0, 12'hFFF);
    send_request(1'b1, 1'b1, 12'h000);
    send_request(1'b0, 1'b0, 12'h000);

    // level above ten clamps to 100 percent; zero period gives a zero count
    quiesce();
    program_settings(1'b1, 1'b0, 4'd15, 12'd0, 16'd0, 1'b0);
    send_request(1'b1, 1'b0, 12'h123);
    send_request(1'b1, 1'b1, 12'hEDC);

    // smallest period, then largest with a mid level
    quiesce();
    program_settings(1'b1, 1'b0, 4'd10, 12'd62, 16'd1, 1'b0);
    send_request(1'b1, 1'b0, 12'h0F0);
    quiesce();
    program_settings(1'b1, 1'b0, 4'd5, 12'd62, 16'hFFFF, 1'b0);
    send_request(1'b1, 1'b0, 12'hF0F);

    // auto mode: the window starts filling, alarm and not-ready ticks leave it alone
    quiesce();
    program_settings(1'b1, 1'b1, 4'd10, 12'd62, 16'd3125, 1'b0);
    send_request(1'b1, 1'b0, 12'hFFF);
    send_request(1'b1, 1'b1, 12'h800);
    send_request(1'b1, 1'b0, 12'h001);
    send_request(1'b0, 1'b0, 12'h7FF);
    send_request(1'b1, 1'b0, 12'h000);
    send_request(1'b1, 1'b0, 12'hFFE);

    // enable cleared again
    quiesce();
    program_settings(1'b0, 1'b1, 4'd3, 12'd62, 16'd3125, 1'b0);
    send_request(1'b1, 1'b0, 12'h3C3);

    // random phases, each with its own settings and idling pattern
    while (items_sent < ITEM_TARGET) begin
      quiesce();
      idle_mode    = $urandom_range(0, 3);
      send_gaps_on = idle_mode[0];
      stall_on     = idle_mode[1];
      lvl          = 4'($urandom);
      case ($urandom_range(0, 9))
        0:       thr = 12'd0;
        1:       thr = 12'hFFF;
        2, 3:    thr = 12'($urandom);
        default: thr = 12'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 19))
        0:       per = 16'd0;
        1:       per = 16'd1;
        2, 3:    per = 16'hFFFF;
        4, 5:    per = 16'd3125;
        default: per = 16'($urandom);
      endcase

      if (!fault_phase_done && items_sent >= ITEM_TARGET / 2) begin
        // a long run of zero codes leaves an all-zero window: sticky sensor failure
        program_settings(1'b1, 1'b1, lvl, thr, per, 1'b0);
        repeat (200) send_request(1'b1, 1'b0, 12'h000);
        fault_phase_done = 1'b1;
      end else begin
        en = ($urandom_range(0, 9) != 0);
        au = ($urandom_range(0, 9) < 7);
        program_settings(en, au, lvl, thr, per, $urandom_range(0, 3) == 0);
        style = $urandom_range(0, 3);
        count = $urandom_range(20, 200);
        repeat (count) begin
          if ($urandom_range(0, 9) == 0) begin
            // noise: every field fully random
            rdy = 1'($urandom);
            alm = 1'($urandom);
            smp = 12'($urandom);
          end else begin
            rdy = ($urandom_range(0, 19) != 0);
            alm = ($urandom_range(0, 11) == 0);
            case (style)
              0: begin
                // hover around the threshold so the dim decision flips
                near = int'(thr) + int'($urandom_range(0, 96)) - 48;
                if (near < 0) near = 0;
                if (near > 4095) near = 4095;
                smp = 12'(near);
              end
              1: smp = 12'($urandom);
              2: smp = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
              // exactly on the threshold, or one below it
              default: smp = ($urandom_range(0, 1) && thr != 0) ? thr - 12'd1 : thr;
            endcase
          end
          send_request(rdy, alm, smp);
          // now and then hold the sender until every result is back
          if ($urandom_range(0, 199) == 0) wait_results_done();
        end
      end
    end

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: ambient_light_backlight_duty_core.f
rtl/core/albd_pkg.sv
rtl/core/albd_cell.sv
rtl/core/albd_window.sv
rtl/core/ambient_light_backlight_duty_core.sv
test/backlight_duty_checker.sv
test/ambient_light_backlight_duty_core_tb.sv
